/* rtl/positional_list_engine_unit_macros.svh */
// Assertion helpers shared by the checker files of the list engine.
// Every assertion samples on the rising clock edge and is switched off while reset is low.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Plain clocked assertion of a property.
`define PLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PLE_IMPLIES(lbl, ante, cons, msg) `PLE_ASSERT(lbl, (ante) |-> (cons), msg)

// Consequent must hold in the cycle after the antecedent.
`define PLE_NEXT(lbl, ante, cons, msg) `PLE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/ple_pkg.sv */
package ple_pkg;

	// Command codes carried by the op field.
	typedef enum logic [2:0] {
		OP_APPEND       = 3'd0,
		OP_REMOVE_LAST  = 3'd1,
		OP_INSERT       = 3'd2,
		OP_REMOVE_AT    = 3'd3,
		OP_REMOVE_VALUE = 3'd4,
		OP_FIND         = 3'd5,
		OP_READ         = 3'd6
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	localparam int DATA_W = 32;

endpackage

/* rtl/ple_ram.sv */
// Simple dual-port store: one write port, one read port with registered read data.
module ple_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/positional_list_engine_unit.sv */
// Ordered list engine: holds up to CAPACITY signed 32-bit entries at positions 0 .. count-1.
// Input channel (in_valid / in_stall) carries one command item: op, value and position.
// Output channel (out_valid / out_stall) returns exactly one result item per command:
// status, found_position, read_value, count and empty_res.
// Commands run one at a time under a small sequencer around a single-port-read store;
// in_stall is high from the cycle after an item is taken until its result is registered.
// Sequencing: append, remove last, op 7 and any rejected command go straight to the finish
// state; read at passes through the read and read-wait states; insert at below the count
// moves the entries at and above the position up one place, then writes the new value;
// remove at moves the entries above the position down; find and remove value compare
// entries in order, and a successful remove value then moves down those above the match.
// The longest command is a remove value on a full list, set by the store's one read per
// cycle during the search and the shift that follows. Each item ends in the finish state.
// Shifts are pipelined: each cycle reads one entry and writes the one read before.
// The result sits in an output register; a new item may be taken while it waits, and that
// item's result is held back in the sequencer until the receiver takes the earlier one.
// Asynchronous reset empties the list and clears all control state; the entry store itself
// is not cleared, since only positions below the count are ever read.
module positional_list_engine_unit #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [31:0] value,
	input  logic [5:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [4:0]         found_position,
	output logic signed [31:0] read_value,
	output logic [5:0]         count,
	output logic               empty_res
);

	// Address width of the store, width of the entry count, and a common width wide enough
	// to compare the 6-bit position with the count.
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UPLAST,
		S_INSV,
		S_SCAN,
		S_DN,
		S_DNLAST,
		S_RD,
		S_RDW,
		S_FIN
	} state_t;

	state_t                   state_q;
	ple_pkg::op_t             op_q;
	logic signed [31:0]       val_q;
	logic [AW-1:0]            pos_q;
	logic [CW-1:0]            idx_q;
	logic [CW-1:0]            cnt_q;
	ple_pkg::status_t         st_q;
	logic [AW-1:0]            fpos_q;
	logic signed [31:0]       rval_q;

	// Shift pipeline: the entry read last cycle is written one place up or down.
	logic                     pend_s1;
	logic [AW-1:0]            wa_s1;
	// Search pipeline: the entry read last cycle is compared with the wanted value.
	logic                     scan_pend_s1;
	logic [AW-1:0]            sidx_s1;

	logic                     out_valid_q;
	ple_pkg::status_t         out_st_q;
	logic [4:0]               out_fpos_q;
	logic signed [31:0]       out_rval_q;
	logic [5:0]               out_cnt_q;
	logic                     out_empty_q;

	logic                     in_take;
	logic [XW-1:0]            cnt_x;
	logic [XW-1:0]            pos_x;
	logic [XW-1:0]            fpos_x;
	logic [CW-1:0]            cnt_last;
	logic                     is_full;
	logic                     is_empty;
	logic                     scan_issue;
	logic                     hit;
	logic                     scan_end;
	logic                     out_free;
	ple_pkg::op_t             op_in;

	logic                     ram_we;
	logic [AW-1:0]            ram_wa;
	logic [ple_pkg::DATA_W-1:0] ram_wd;
	logic [AW-1:0]            ram_ra;
	logic [ple_pkg::DATA_W-1:0] ram_rd;

	assign op_in      = ple_pkg::op_t'(op);
	assign in_take    = in_valid && (state_q == S_IDLE);
	assign in_stall   = (state_q != S_IDLE);
	assign cnt_x      = XW'(cnt_q);
	assign pos_x      = XW'(position);
	assign fpos_x     = XW'(fpos_q);
	assign cnt_last   = cnt_q - CW'(1);
	assign is_full    = (cnt_q == CAP_C);
	assign is_empty   = (cnt_q == '0);
	assign scan_issue = (state_q == S_SCAN) && (idx_q < cnt_q);
	assign hit        = scan_pend_s1 && (ram_rd == val_q);
	assign scan_end   = scan_pend_s1 && (CW'(sidx_s1) == cnt_last);
	assign out_free   = !out_valid_q || !out_stall;
	assign ram_ra     = idx_q[AW-1:0];

	// One write port serves the shift pipeline, the insert slot and a direct write at the end
	// for append or insert at the count. The sequencer never asks for two of these in the same cycle.
	always_comb begin
		ram_we = 1'b0;
		ram_wa = pos_q;
		ram_wd = val_q;
		if (pend_s1) begin
			ram_we = 1'b1;
			ram_wa = wa_s1;
			ram_wd = ram_rd;
		end else if (state_q == S_INSV) begin
			ram_we = 1'b1;
		end else if (in_take && !is_full &&
			((op_in == ple_pkg::OP_APPEND) ||
			((op_in == ple_pkg::OP_INSERT) && (pos_x == cnt_x)))) begin
			ram_we = 1'b1;
			ram_wa = cnt_q[AW-1:0];
			ram_wd = value;
		end
	end

	ple_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(ple_pkg::DATA_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_wa),
		.wdata(ram_wd),
		.raddr(ram_ra),
		.rdata(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= ple_pkg::OP_APPEND;
			val_q        <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			st_q         <= ple_pkg::ST_OK;
			fpos_q       <= '0;
			rval_q       <= '0;
			pend_s1      <= 1'b0;
			wa_s1        <= '0;
			scan_pend_s1 <= 1'b0;
			sidx_s1      <= '0;
			out_valid_q  <= 1'b0;
			out_st_q     <= ple_pkg::ST_OK;
			out_fpos_q   <= '0;
			out_rval_q   <= '0;
			out_cnt_q    <= '0;
			out_empty_q  <= 1'b1;
		end else begin
			pend_s1      <= (state_q == S_UP) || (state_q == S_DN);
			wa_s1        <= (state_q == S_UP) ? (idx_q[AW-1:0] + AW'(1))
				: (idx_q[AW-1:0] - AW'(1));
			scan_pend_s1 <= scan_issue;
			sidx_s1      <= idx_q[AW-1:0];

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						op_q    <= op_in;
						val_q   <= value;
						pos_q   <= pos_x[AW-1:0];
						st_q    <= ple_pkg::ST_OK;
						fpos_q  <= '0;
						rval_q  <= '0;
						state_q <= S_FIN;
						case (op_in)
							ple_pkg::OP_APPEND: begin
								if (is_full) begin
									st_q <= ple_pkg::ST_FULL;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							ple_pkg::OP_REMOVE_LAST: begin
								if (is_empty) begin
									st_q <= ple_pkg::ST_EMPTY;
								end else begin
									cnt_q <= cnt_last;
								end
							end
							ple_pkg::OP_INSERT: begin
								if (is_full) begin
									st_q <= ple_pkg::ST_FULL;
								end else if (pos_x > cnt_x) begin
									st_q <= ple_pkg::ST_BAD_POS;
								end else if (pos_x == cnt_x) begin
									cnt_q <= cnt_q + CW'(1);
								end else begin
									// Walk down from the last entry, moving each one up.
									idx_q   <= cnt_last;
									state_q <= S_UP;
								end
							end
							ple_pkg::OP_REMOVE_AT: begin
								if (pos_x >= cnt_x) begin
									st_q <= ple_pkg::ST_BAD_POS;
								end else begin
									fpos_q <= pos_x[AW-1:0];
									if (pos_x == XW'(cnt_last)) begin
										state_q <= S_DNLAST;
									end else begin
										idx_q   <= pos_x[CW-1:0] + CW'(1);
										state_q <= S_DN;
									end
								end
							end
							ple_pkg::OP_REMOVE_VALUE, ple_pkg::OP_FIND: begin
								if (is_empty) begin
									st_q <= ple_pkg::ST_NOT_FOUND;
								end else begin
									idx_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							ple_pkg::OP_READ: begin
								if (pos_x >= cnt_x) begin
									st_q <= ple_pkg::ST_BAD_POS;
								end else begin
									idx_q   <= pos_x[CW-1:0];
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_UP: begin
					if (idx_q == CW'(pos_q)) begin
						state_q <= S_UPLAST;
					end else begin
						idx_q <= idx_q - CW'(1);
					end
				end
				S_UPLAST: begin
					state_q <= S_INSV;
				end
				S_INSV: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_FIN;
				end
				S_SCAN: begin
					if (scan_issue) begin
						idx_q <= idx_q + CW'(1);
					end
					if (hit) begin
						scan_pend_s1 <= 1'b0;
						fpos_q       <= sidx_s1;
						if (op_q == ple_pkg::OP_FIND) begin
							state_q <= S_FIN;
						end else if (CW'(sidx_s1) == cnt_last) begin
							state_q <= S_DNLAST;
						end else begin
							idx_q   <= CW'(sidx_s1) + CW'(1);
							state_q <= S_DN;
						end
					end else if (scan_end) begin
						scan_pend_s1 <= 1'b0;
						st_q         <= ple_pkg::ST_NOT_FOUND;
						state_q      <= S_FIN;
					end
				end
				S_DN: begin
					if (idx_q == cnt_last) begin
						state_q <= S_DNLAST;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DNLAST: begin
					cnt_q   <= cnt_last;
					state_q <= S_FIN;
				end
				S_RD: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					rval_q  <= ram_rd;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_st_q    <= st_q;
						out_fpos_q  <= fpos_x[4:0];
						out_rval_q  <= rval_q;
						out_cnt_q   <= cnt_x[5:0];
						out_empty_q <= is_empty;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_st_q;
	assign found_position = out_fpos_q;
	assign read_value     = out_rval_q;
	assign count          = out_cnt_q;
	assign empty_res      = out_empty_q;

endmodule

/* rtl/ple_checker.sv */
`include "positional_list_engine_unit_macros.svh"

// Port-level checks on the list engine.
module ple_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         status,
	input logic [4:0]         found_position,
	input logic signed [31:0] read_value,
	input logic [5:0]         count,
	input logic               empty_res
);

	`PLE_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(count) && $stable(read_value), "stalled result changed")
	`PLE_IMPLIES(a_empty_flag, out_valid, empty_res == (count == 6'd0), "empty flag disagrees with count")
	`PLE_IMPLIES(a_status_range, out_valid, status <= ple_pkg::ST_EMPTY, "status code out of range")
	`PLE_IMPLIES(a_fail_clean, out_valid && (status != ple_pkg::ST_OK), (read_value == 32'sd0) && (found_position == 5'd0), "failed command returned data")
	`PLE_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "engine took a second item at once")

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);
